@@ sv/rmq_pkg.sv @@
package rmq_pkg;

   localparam int IQ           = 28;
   localparam int M_BITS       = 30;
   localparam int Y_BITS       = 30;
   localparam int P_BITS       = 32;
   localparam int E_BITS       = 30;
   localparam int TQ_BITS      = 31;
   localparam int NEWTON_STEPS = 3;

   typedef enum logic [1:0] {
      K_LOW  = 2'd0,
      K_MID  = 2'd1,
      K_HIGH = 2'd2
   } kexp_type;

   typedef struct packed {
      logic [M_BITS-1:0] m;
      logic [Y_BITS-1:0] y;
      kexp_type          k;
   } rsq_type;

   function automatic logic [15:0] seed_q16(input logic [3:0] idx);
      logic [15:0] s;
      case (idx)
         4'd4:    s = 16'd61788;
         4'd5:    s = 16'd55889;
         4'd6:    s = 16'd51411;
         4'd7:    s = 16'd47861;
         4'd8:    s = 16'd44957;
         4'd9:    s = 16'd42525;
         4'd10:   s = 16'd40450;
         4'd11:   s = 16'd38651;
         4'd12:   s = 16'd37073;
         4'd13:   s = 16'd35673;
         4'd14:   s = 16'd34422;
         4'd15:   s = 16'd33292;
         default: s = 16'd61788;
      endcase
      return s;
   endfunction

endpackage

@@ sv/rmq_front.sv @@
module rmq_front #(
   parameter int ELEMENT_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic [8:0][ELEMENT_BITS-1:0]       in_elem,
   output logic                               out_valid,
   input  logic                               out_ready,
   output rmq_pkg::rsq_type                   out_rsq,
   output logic [3:0][ELEMENT_BITS+1:0]       out_comp
);
   import rmq_pkg::*;

   localparam int T_BITS    = ELEMENT_BITS + 2;
   localparam int FRAC_BITS = ELEMENT_BITS - 2;
   localparam logic signed [T_BITS-1:0] T_ONE = T_BITS'(1) << FRAC_BITS;
   localparam logic signed [T_BITS-1:0] T_LO  = T_BITS'(1) << (FRAC_BITS - 2);
   localparam logic signed [T_BITS-1:0] T_HI  = T_BITS'(1) << ELEMENT_BITS;

   typedef enum logic [1:0] {SLOT_X, SLOT_Y, SLOT_Z, SLOT_W} slot_type;

   logic valid_a_ff, valid_b_ff, ready_a, ready_b;

   logic signed [T_BITS-1:0] a [9];
   logic signed [T_BITS-1:0] t_in, t_ff;
   logic [3:0][T_BITS-1:0]   comp_a_in, comp_a_ff;
   slot_type                 slot_in, slot_ff;

   logic signed [T_BITS-1:0] t_c;
   logic [ELEMENT_BITS:0]    t_u;
   logic [TQ_BITS-1:0]       tq;
   logic [3:0][T_BITS-1:0]   comp_b_in, comp_b_ff;
   rsq_type                  rsq_in, rsq_ff;

   assign ready_b  = !valid_b_ff || out_ready;
   assign ready_a  = !valid_a_ff || ready_b;
   assign in_ready = ready_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         if (ready_a) valid_a_ff <= in_valid;
         if (ready_b) valid_b_ff <= valid_a_ff;
      end
   end

   // branch select and sums
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         a[i] = T_BITS'($signed(in_elem[i]));
      end
      comp_a_in = '0;
      if (a[8] < 0) begin
         if (a[0] > a[4]) begin
            t_in         = T_ONE + a[0] - a[4] - a[8];
            comp_a_in[1] = a[1] + a[3];
            comp_a_in[2] = a[6] + a[2];
            comp_a_in[3] = a[5] - a[7];
            slot_in      = SLOT_X;
         end else begin
            t_in         = T_ONE - a[0] + a[4] - a[8];
            comp_a_in[0] = a[1] + a[3];
            comp_a_in[2] = a[5] + a[7];
            comp_a_in[3] = a[6] - a[2];
            slot_in      = SLOT_Y;
         end
      end else begin
         if ((a[0] + a[4]) < 0) begin
            t_in         = T_ONE - a[0] - a[4] + a[8];
            comp_a_in[0] = a[6] + a[2];
            comp_a_in[1] = a[5] + a[7];
            comp_a_in[3] = a[1] - a[3];
            slot_in      = SLOT_Z;
         end else begin
            t_in         = T_ONE + a[0] + a[4] + a[8];
            comp_a_in[0] = a[5] - a[7];
            comp_a_in[1] = a[6] - a[2];
            comp_a_in[2] = a[1] - a[3];
            slot_in      = SLOT_W;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a && in_valid) begin
         t_ff      <= t_in;
         comp_a_ff <= comp_a_in;
         slot_ff   <= slot_in;
      end
   end

   // clamp, normalise to [1,4) and seed
   always_comb begin
      if (t_ff < T_LO) begin
         t_c = T_LO;
      end else if (t_ff > T_HI) begin
         t_c = T_HI;
      end else begin
         t_c = t_ff;
      end
      comp_b_in = comp_a_ff;
      case (slot_ff)
         SLOT_X:  comp_b_in[0] = t_c;
         SLOT_Y:  comp_b_in[1] = t_c;
         SLOT_Z:  comp_b_in[2] = t_c;
         SLOT_W:  comp_b_in[3] = t_c;
         default: comp_b_in[3] = t_c;
      endcase
   end

   assign t_u = t_c[ELEMENT_BITS:0];

   generate
      if (FRAC_BITS <= IQ) begin : g_tq_left
         assign tq = TQ_BITS'(t_u) << (IQ - FRAC_BITS);
      end else begin : g_tq_right
         assign tq = TQ_BITS'(t_u >> (FRAC_BITS - IQ));
      end
   endgenerate

   always_comb begin
      if (tq[TQ_BITS-1:IQ] == '0) begin
         rsq_in.m = {tq[IQ-1:0], 2'b00};
         rsq_in.k = K_LOW;
      end else if (tq[TQ_BITS-1]) begin
         rsq_in.m = M_BITS'(tq[TQ_BITS-1:2]);
         rsq_in.k = K_HIGH;
      end else begin
         rsq_in.m = tq[M_BITS-1:0];
         rsq_in.k = K_MID;
      end
      rsq_in.y = Y_BITS'(seed_q16(rsq_in.m[M_BITS-1:M_BITS-4])) << (IQ - 16);
   end

   always_ff @(posedge clock) begin
      if (ready_b && valid_a_ff) begin
         rsq_ff    <= rsq_in;
         comp_b_ff <= comp_b_in;
      end
   end

   assign out_valid = valid_b_ff;
   assign out_rsq   = rsq_ff;
   assign out_comp  = comp_b_ff;

endmodule

@@ sv/rmq_newton.sv @@
module rmq_newton #(
   parameter int ELEMENT_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  rmq_pkg::rsq_type             in_rsq,
   input  logic [3:0][ELEMENT_BITS+1:0] in_comp,
   output logic                         out_valid,
   input  logic                         out_ready,
   output rmq_pkg::rsq_type             out_rsq,
   output logic [3:0][ELEMENT_BITS+1:0] out_comp
);
   import rmq_pkg::*;

   localparam logic [P_BITS-1:0] THREE = P_BITS'(3) << IQ;

   logic [2:0] valid_ff;
   logic [2:0] ready;

   rsq_type                      rsq0_ff, rsq1_ff, rsq2_ff, rsq2_in;
   logic [3:0][ELEMENT_BITS+1:0] comp0_ff, comp1_ff, comp2_ff;
   logic [2*Y_BITS-1:0]          sq;
   logic [Y_BITS-1:0]            y2_in, y2_ff;
   logic [M_BITS+Y_BITS-1:0]     mp;
   logic [P_BITS-1:0]            p_in, p_ff;
   logic [E_BITS-1:0]            e;
   logic [Y_BITS+E_BITS-1:0]     ye;

   assign ready[2]  = !valid_ff[2] || out_ready;
   assign ready[1]  = !valid_ff[1] || ready[2];
   assign ready[0]  = !valid_ff[0] || ready[1];
   assign in_ready  = ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[0]) valid_ff[0] <= in_valid;
         if (ready[1]) valid_ff[1] <= valid_ff[0];
         if (ready[2]) valid_ff[2] <= valid_ff[1];
      end
   end

   // y squared
   assign sq    = in_rsq.y * in_rsq.y;
   assign y2_in = sq[IQ +: Y_BITS];

   always_ff @(posedge clock) begin
      if (ready[0] && in_valid) begin
         rsq0_ff  <= in_rsq;
         comp0_ff <= in_comp;
         y2_ff    <= y2_in;
      end
   end

   // m times y squared
   assign mp   = rsq0_ff.m * y2_ff;
   assign p_in = mp[IQ +: P_BITS];

   always_ff @(posedge clock) begin
      if (ready[1] && valid_ff[0]) begin
         rsq1_ff  <= rsq0_ff;
         comp1_ff <= comp0_ff;
         p_ff     <= p_in;
      end
   end

   // y (3 - m y^2) / 2
   always_comb begin
      if (p_ff >= THREE) begin
         e = '0;
      end else begin
         e = E_BITS'(THREE - p_ff);
      end
      ye        = rsq1_ff.y * e;
      rsq2_in   = rsq1_ff;
      rsq2_in.y = ye[IQ+1 +: Y_BITS];
   end

   always_ff @(posedge clock) begin
      if (ready[2] && valid_ff[1]) begin
         rsq2_ff  <= rsq2_in;
         comp2_ff <= comp1_ff;
      end
   end

   assign out_valid = valid_ff[2];
   assign out_rsq   = rsq2_ff;
   assign out_comp  = comp2_ff;

endmodule

@@ sv/rmq_scale.sv @@
module rmq_scale #(
   parameter int ELEMENT_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  rmq_pkg::rsq_type             in_rsq,
   input  logic [3:0][ELEMENT_BITS+1:0] in_comp,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [3:0][ELEMENT_BITS-1:0] out_quat
);
   import rmq_pkg::*;

   localparam int MAG_BITS  = ELEMENT_BITS + 1;
   localparam int PROD_BITS = MAG_BITS + Y_BITS;
   localparam int R_BITS    = PROD_BITS - IQ;
   localparam logic [PROD_BITS-1:0] RND    = PROD_BITS'(1) << (IQ - 1);
   localparam logic [R_BITS-1:0]    MAXPOS = R_BITS'({(ELEMENT_BITS-1){1'b1}});
   localparam logic [R_BITS-1:0]    MINMAG = MAXPOS + R_BITS'(1);

   logic [1:0] valid_ff;
   logic [1:0] ready;

   logic [Y_BITS-1:0]                  s;
   logic [3:0]                         neg_in, neg_ff;
   logic [3:0][MAG_BITS-1:0]           mag;
   logic [3:0][PROD_BITS-1:0]          prod_in, prod_ff;
   logic [3:0][PROD_BITS-1:0]          rnd;
   logic [3:0][R_BITS-1:0]             r;
   logic [3:0][ELEMENT_BITS-1:0]       quat_in, quat_ff;

   assign ready[1] = !valid_ff[1] || out_ready;
   assign ready[0] = !valid_ff[0] || ready[1];
   assign in_ready = ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[0]) valid_ff[0] <= in_valid;
         if (ready[1]) valid_ff[1] <= valid_ff[0];
      end
   end

   // undo the normalisation and halve
   always_comb begin
      case (in_rsq.k)
         K_LOW:   s = in_rsq.y;
         K_MID:   s = in_rsq.y >> 1;
         K_HIGH:  s = in_rsq.y >> 2;
         default: s = in_rsq.y >> 1;
      endcase
      for (int j = 0; j < 4; j++) begin
         neg_in[j]  = in_comp[j][ELEMENT_BITS+1];
         mag[j]     = neg_in[j] ? MAG_BITS'(-in_comp[j]) : MAG_BITS'(in_comp[j]);
         prod_in[j] = PROD_BITS'(mag[j]) * PROD_BITS'(s);
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0] && in_valid) begin
         prod_ff <= prod_in;
         neg_ff  <= neg_in;
      end
   end

   // round half away from zero, then saturate
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         rnd[j] = prod_ff[j] + RND;
         r[j]   = rnd[j][PROD_BITS-1:IQ];
         if (neg_ff[j]) begin
            if (r[j] > MINMAG) begin
               quat_in[j] = {1'b1, {(ELEMENT_BITS-1){1'b0}}};
            end else begin
               quat_in[j] = ELEMENT_BITS'(0) - r[j][ELEMENT_BITS-1:0];
            end
         end else begin
            if (r[j] > MAXPOS) begin
               quat_in[j] = MAXPOS[ELEMENT_BITS-1:0];
            end else begin
               quat_in[j] = r[j][ELEMENT_BITS-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready[1] && valid_ff[0]) begin
         quat_ff <= quat_in;
      end
   end

   assign out_valid = valid_ff[1];
   assign out_quat  = quat_ff;

endmodule

@@ sv/rotation_matrix_to_quaternion_core.sv @@
// rotation matrix to quaternion converter
//
// req channel: one transaction carries a whole 3x3 matrix, nine signed
// elements with ELEMENT_BITS-2 fraction bits. rsp channel: one transaction
// carries the quaternion x, y, z, w in the same format, saturated.
// every request transaction gives exactly one response transaction, in order.
//
// throughput: one transaction per clock cycle while rsp_tready keeps the
// output moving. a matrix passes branch select, then clamp and seed
// lookup, then three Newton steps (y squared, m times y squared, update;
// one multiplier per stage), then scaling, then rounding and saturation.
//
// reset clears every stage valid bit; matrices in flight are dropped.
// when rsp_tready is low the result holds in the output register and earlier
// stages keep filling any empty slots; req_tready drops only once every
// stage holds a matrix.
module rotation_matrix_to_quaternion_core #(
   parameter int ELEMENT_BITS = 16,
   localparam int REQ_BITS = ((9 * ELEMENT_BITS + 7) / 8) * 8,
   localparam int RSP_BITS = ((4 * ELEMENT_BITS + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [REQ_BITS-1:0] req_tdata,  // m11, m12, m13, m21, m22, m23, m31, m32, m33
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_BITS-1:0] rsp_tdata   // quat_x, quat_y, quat_z, quat_w
);
   import rmq_pkg::*;

   logic [8:0][ELEMENT_BITS-1:0] elem;
   logic [3:0][ELEMENT_BITS-1:0] quat;

   logic [NEWTON_STEPS:0]        stage_valid;
   logic [NEWTON_STEPS:0]        stage_ready;
   rsq_type                      stage_rsq  [NEWTON_STEPS+1];
   logic [3:0][ELEMENT_BITS+1:0] stage_comp [NEWTON_STEPS+1];

   assign elem = req_tdata[9*ELEMENT_BITS-1:0];

   rmq_front #(.ELEMENT_BITS(ELEMENT_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_elem   (elem),
      .out_valid (stage_valid[0]),
      .out_ready (stage_ready[0]),
      .out_rsq   (stage_rsq[0]),
      .out_comp  (stage_comp[0])
   );

   for (genvar i = 0; i < NEWTON_STEPS; i++) begin : g_newton
      rmq_newton #(.ELEMENT_BITS(ELEMENT_BITS)) u_newton (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[i]),
         .in_ready  (stage_ready[i]),
         .in_rsq    (stage_rsq[i]),
         .in_comp   (stage_comp[i]),
         .out_valid (stage_valid[i+1]),
         .out_ready (stage_ready[i+1]),
         .out_rsq   (stage_rsq[i+1]),
         .out_comp  (stage_comp[i+1])
      );
   end

   rmq_scale #(.ELEMENT_BITS(ELEMENT_BITS)) u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid[NEWTON_STEPS]),
      .in_ready  (stage_ready[NEWTON_STEPS]),
      .in_rsq    (stage_rsq[NEWTON_STEPS]),
      .in_comp   (stage_comp[NEWTON_STEPS]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_quat  (quat)
   );

   assign rsp_tdata = RSP_BITS'(quat);

`ifndef SYNTHESIS
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_input_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input refused without a stalled response");

   a_scale_stall: assert property (@(posedge clock) disable iff (reset)
      !stage_ready[NEWTON_STEPS] |-> (rsp_tvalid && !rsp_tready))
      else $error("scaling stage blocked without a stalled response");

   a_front_stall: assert property (@(posedge clock) disable iff (reset)
      !stage_ready[0] |-> (stage_valid[NEWTON_STEPS] && !stage_ready[NEWTON_STEPS]))
      else $error("newton pipe blocked while its tail can move");
`endif

endmodule

@@ test/testbench.sv @@
module testbench;
   import rmq_pkg::*;

   localparam int EB       = 16;
   localparam int FB       = EB - 2;
   localparam int REQ_BITS = ((9 * EB + 7) / 8) * 8;
   localparam int RSP_BITS = ((4 * EB + 7) / 8) * 8;

   localparam int     UNIT   = 1 << FB;
   localparam longint T_LOW  = longint'(1) << (FB - 2);
   localparam longint T_HIGH = longint'(4) << FB;

   localparam int RANDOM_COUNT = 1200;
   localparam int DRAIN_AT     = 450;
   localparam int LONG_HOLD_AT = 700;
   localparam int LONG_HOLD    = 80;
   localparam int TAIL_CYCLES  = 40;

   typedef enum int {
      AXIS_X = 0,
      AXIS_Y = 1,
      AXIS_Z = 2,
      AXIS_W = 3
   } axis_type;

   // x in the lowest bits, as on rsp_tdata
   typedef struct packed {
      logic [EB-1:0] w;
      logic [EB-1:0] z;
      logic [EB-1:0] y;
      logic [EB-1:0] x;
   } quat_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_BITS-1:0] req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_BITS-1:0] rsp_tdata;

   logic [REQ_BITS-1:0] matrices_to_send [$];
   quat_type            pending_quats [$];
   longint unsigned     root_seed [12] = '{
      61788, 55889, 51411, 47861, 44957, 42525,
      40450, 38651, 37073, 35673, 34422, 33292
   };

   int  matrix_total = 0;
   int  directed_count = 0;
   int  matrices_accepted = 0;
   int  quats_checked = 0;
   int  mismatches = 0;
   int  pivot_hits [4] = '{0, 0, 0, 0};
   int  t_clamped = 0;
   bit  req_fired = 1'b0;
   int  send_gap = 0;
   bit  drain_done = 1'b0;
   int  hold_cycles = 0;
   bit  long_hold_done = 1'b0;

   rotation_matrix_to_quaternion_core #(.ELEMENT_BITS(EB)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // 0.5/sqrt(t) in Q.28, t in Q.FB and already clamped
   function automatic longint unsigned half_inv_root(input longint t);
      longint unsigned tq;
      longint unsigned m;
      longint unsigned y;
      longint unsigned y2;
      longint unsigned p;
      longint unsigned e;
      longint unsigned idx;
      kexp_type        k;
      tq = t;
      tq = tq << (IQ - FB);
      if (tq < (64'd1 << IQ)) begin
         m = tq << 2;
         k = K_LOW;
      end else if (tq >= (64'd1 << (IQ + 2))) begin
         m = tq >> 2;
         k = K_HIGH;
      end else begin
         m = tq;
         k = K_MID;
      end
      idx = m >> (IQ - 2);
      if (idx < 4) idx = 4;
      if (idx > 15) idx = 15;
      y = root_seed[idx - 4] << (IQ - 16);
      for (int i = 0; i < NEWTON_STEPS; i++) begin
         y2 = (y * y) >> IQ;
         p = (m * y2) >> IQ;
         e = (p >= (64'd3 << IQ)) ? 64'd0 : (64'd3 << IQ) - p;
         y = (y * e) >> (IQ + 1);
      end
      case (k)
         K_LOW:   y = y << 1;
         K_HIGH:  y = y >> 1;
         default: y = y;
      endcase
      return y >> 1;
   endfunction

   // round half away from zero, then saturate
   function automatic logic [EB-1:0] scaled_component(input longint v, input longint unsigned s);
      longint unsigned mag;
      longint unsigned prod;
      if (v < 0) mag = -v;
      else mag = v;
      prod = (mag * s + (64'd1 << (IQ - 1))) >> IQ;
      if (v < 0) begin
         if (prod > (64'd1 << (EB - 1))) prod = 64'd1 << (EB - 1);
         prod = -prod;
      end else if (prod > ((64'd1 << (EB - 1)) - 1)) begin
         prod = (64'd1 << (EB - 1)) - 1;
      end
      return prod[EB-1:0];
   endfunction

   function automatic quat_type quaternion_of(input logic [REQ_BITS-1:0] d);
      longint          a [9];
      longint          c [4];
      longint          t;
      longint unsigned s;
      axis_type        slot;
      quat_type        q;
      for (int i = 0; i < 9; i++) a[i] = longint'($signed(d[EB*i +: EB]));
      if (a[8] < 0) begin
         if (a[0] > a[4]) begin
            slot = AXIS_X;
            t = UNIT + a[0] - a[4] - a[8];
            c[AXIS_Y] = a[1] + a[3];
            c[AXIS_Z] = a[6] + a[2];
            c[AXIS_W] = a[5] - a[7];
         end else begin
            slot = AXIS_Y;
            t = UNIT - a[0] + a[4] - a[8];
            c[AXIS_X] = a[1] + a[3];
            c[AXIS_Z] = a[5] + a[7];
            c[AXIS_W] = a[6] - a[2];
         end
      end else if (a[0] < -a[4]) begin
         slot = AXIS_Z;
         t = UNIT - a[0] - a[4] + a[8];
         c[AXIS_X] = a[6] + a[2];
         c[AXIS_Y] = a[5] + a[7];
         c[AXIS_W] = a[1] - a[3];
      end else begin
         slot = AXIS_W;
         t = UNIT + a[0] + a[4] + a[8];
         c[AXIS_X] = a[5] - a[7];
         c[AXIS_Y] = a[6] - a[2];
         c[AXIS_Z] = a[1] - a[3];
      end
      if (t < T_LOW) begin
         t = T_LOW;
         t_clamped++;
      end
      if (t > T_HIGH) begin
         t = T_HIGH;
         t_clamped++;
      end
      c[slot] = t;
      pivot_hits[slot]++;
      s = half_inv_root(t);
      q.x = scaled_component(c[AXIS_X], s);
      q.y = scaled_component(c[AXIS_Y], s);
      q.z = scaled_component(c[AXIS_Z], s);
      q.w = scaled_component(c[AXIS_W], s);
      return q;
   endfunction

   function automatic logic [REQ_BITS-1:0] pack_matrix(input int a11, a12, a13,
                                                       input int a21, a22, a23,
                                                       input int a31, a32, a33);
      return {a33[EB-1:0], a32[EB-1:0], a31[EB-1:0],
              a23[EB-1:0], a22[EB-1:0], a21[EB-1:0],
              a13[EB-1:0], a12[EB-1:0], a11[EB-1:0]};
   endfunction

   task automatic queue_matrix(input logic [REQ_BITS-1:0] d);
      matrices_to_send.insert(matrices_to_send.size(), d);
   endtask

   function automatic int jitter(input int amount);
      return int'($urandom_range(0, 2 * amount)) - amount;
   endfunction

   // proper rotation from a random quaternion, plus some noise
   function automatic logic [REQ_BITS-1:0] rotation_matrix(input int noise);
      real qx;
      real qy;
      real qz;
      real qw;
      real n;
      real r [9];
      int  e [9];
      qx = real'(int'($urandom_range(0, 2000)) - 1000);
      qy = real'(int'($urandom_range(0, 2000)) - 1000);
      qz = real'(int'($urandom_range(0, 2000)) - 1000);
      qw = real'(int'($urandom_range(0, 2000)) - 1000);
      n = $sqrt(qx * qx + qy * qy + qz * qz + qw * qw);
      if (n < 1.0) begin
         qw = 1.0;
         n = 1.0;
      end
      qx = qx / n;
      qy = qy / n;
      qz = qz / n;
      qw = qw / n;
      r[0] = 1.0 - 2.0 * (qy * qy + qz * qz);
      r[1] = 2.0 * (qx * qy - qz * qw);
      r[2] = 2.0 * (qx * qz + qy * qw);
      r[3] = 2.0 * (qx * qy + qz * qw);
      r[4] = 1.0 - 2.0 * (qx * qx + qz * qz);
      r[5] = 2.0 * (qy * qz - qx * qw);
      r[6] = 2.0 * (qx * qz - qy * qw);
      r[7] = 2.0 * (qy * qz + qx * qw);
      r[8] = 1.0 - 2.0 * (qx * qx + qy * qy);
      for (int i = 0; i < 9; i++) e[i] = $rtoi(r[i] * real'(UNIT)) + jitter(noise);
      return pack_matrix(e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]);
   endfunction

   function automatic int extreme_value();
      case ($urandom_range(0, 7))
         0:       return -32768;
         1:       return 32767;
         2:       return -1;
         3:       return 0;
         4:       return 1;
         5:       return 16384;
         6:       return -16384;
         default: return -32767;
      endcase
   endfunction

   function automatic bit idling_on(input int n);
      return (n >= directed_count && n < 400) || (n >= 550 && n < matrix_total - 200);
   endfunction

   task automatic check_field(input string name, input logic [EB-1:0] want, got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
         mismatches++;
      end
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_fired) begin
            matrices_to_send.delete(0);
            if (idling_on(matrices_accepted) && $urandom_range(0, 7) == 0)
               send_gap = $urandom_range(1, 6);
         end
         if (req_tvalid && !req_fired) begin
            // transaction still on offer
         end else if (!drain_done && matrices_accepted >= DRAIN_AT) begin
            req_tvalid <= 1'b0;
            if (pending_quats.size() == 0) drain_done = 1'b1;
         end else if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (matrices_to_send.size() == 0) begin
            req_tvalid <= 1'b0;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata <= matrices_to_send[0];
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (!long_hold_done && matrices_accepted >= LONG_HOLD_AT) begin
            long_hold_done = 1'b1;
            hold_cycles = LONG_HOLD;
         end else if (hold_cycles == 0 && idling_on(matrices_accepted)
                      && $urandom_range(0, 7) == 0) begin
            hold_cycles = $urandom_range(1, 6);
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      quat_type got;
      quat_type want;
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            pending_quats.insert(pending_quats.size(), quaternion_of(req_tdata));
            matrices_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (pending_quats.size() == 0) begin
               $error("rsp transaction with no matrix outstanding");
               mismatches++;
            end else begin
               want = pending_quats.pop_front();
               check_field("quat_x", want.x, got.x);
               check_field("quat_y", want.y, got.y);
               check_field("quat_z", want.z, got.z);
               check_field("quat_w", want.w, got.w);
               quats_checked++;
            end
         end
      end
   end

   initial begin
      int kind;
      int lo;
      int hi;
      lo = -32768;
      hi = 32767;
      queue_matrix(pack_matrix(UNIT, 0, 0, 0, UNIT, 0, 0, 0, UNIT));
      queue_matrix(pack_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0));
      queue_matrix(pack_matrix(UNIT, 0, 0, 0, -UNIT, 0, 0, 0, -UNIT));
      queue_matrix(pack_matrix(-UNIT, 0, 0, 0, UNIT, 0, 0, 0, -UNIT));
      queue_matrix(pack_matrix(-UNIT, 0, 0, 0, -UNIT, 0, 0, 0, UNIT));
      queue_matrix(pack_matrix(0, -UNIT, 0, UNIT, 0, 0, 0, 0, UNIT));
      queue_matrix(pack_matrix(UNIT, 0, 0, 0, 0, -UNIT, 0, UNIT, 0));
      queue_matrix(pack_matrix(0, UNIT, 0, UNIT, 0, 0, 0, 0, -UNIT));
      queue_matrix(pack_matrix(hi, hi, hi, hi, hi, hi, hi, hi, hi));
      queue_matrix(pack_matrix(lo, lo, lo, lo, lo, lo, lo, lo, lo));
      // m11 equal to m22 with m33 just negative
      queue_matrix(pack_matrix(5000, 100, -200, 300, 5000, 400, -500, 600, -1));
      // m11 equal to -m22 with m33 zero
      queue_matrix(pack_matrix(7000, 1, 2, 3, -7000, 4, 5, 6, 0));
      // off-diagonal terms driving the outputs into saturation
      queue_matrix(pack_matrix(0, hi, lo, lo, 0, hi, hi, lo, 0));
      queue_matrix(pack_matrix(0, lo, hi, hi, 0, lo, lo, hi, 0));
      queue_matrix(pack_matrix(hi, hi, hi, hi, lo, hi, hi, hi, lo));
      queue_matrix(pack_matrix(lo, lo, lo, lo, hi, lo, lo, lo, lo));
      // t just over the upper clamp, and t near a seed boundary
      queue_matrix(pack_matrix(UNIT, 0, 0, 0, UNIT, 0, 0, 0, UNIT + 1));
      queue_matrix(pack_matrix(8191, 0, 0, 0, 0, 0, 0, 0, 0));
      queue_matrix(pack_matrix(21845, 21845, 21845, 21845, 21845,
                               21845, 21845, 21845, 21845));
      queue_matrix(pack_matrix(-21846, -21846, -21846, -21846, -21846,
                               -21846, -21846, -21846, -21846));
      queue_matrix(pack_matrix(lo, hi, lo, hi, lo, hi, lo, hi, lo));
      directed_count = matrices_to_send.size();

      for (int i = 0; i < RANDOM_COUNT; i++) begin
         kind = $urandom_range(0, 9);
         if (kind < 5) begin
            queue_matrix(rotation_matrix($urandom_range(0, 8)));
         end else if (kind == 5) begin
            queue_matrix(rotation_matrix($urandom_range(100, 3000)));
         end else if (kind < 8) begin
            queue_matrix(pack_matrix($urandom, $urandom, $urandom,
                                     $urandom, $urandom, $urandom,
                                     $urandom, $urandom, $urandom));
         end else if (kind == 8) begin
            queue_matrix(pack_matrix(extreme_value(), extreme_value(),
                                     extreme_value(), extreme_value(),
                                     extreme_value(), extreme_value(),
                                     extreme_value(), extreme_value(),
                                     extreme_value()));
         end else begin
            queue_matrix(pack_matrix(jitter(20000), $urandom, $urandom,
                                     $urandom, jitter(20000), $urandom,
                                     $urandom, $urandom, jitter(20000)));
         end
      end
      matrix_total = matrices_to_send.size();

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (matrices_accepted < matrix_total || pending_quats.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d matrices (%0d directed) converted, %0d quaternions checked",
               matrices_accepted, directed_count, quats_checked);
      $display("pivot x/y/z/w: %0d/%0d/%0d/%0d, t clamped %0d times",
               pivot_hits[AXIS_X], pivot_hits[AXIS_Y], pivot_hits[AXIS_Z],
               pivot_hits[AXIS_W], t_clamped);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
